>>> design/sef_pkg.sv
// shared types and constants for the singleton element filter
package sef_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int VALUE_W      = 32;

    // one result request from the sequencer to the output register
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic                      found;
        logic                      run_end;
        logic                      overflowed;
    } sef_result_t;

endpackage

>>> design/singleton_element_filter_unit.sv
// top level of the singleton element filter
// Values are loaded one per cycle while s_axis_tready is high; items past
// MAX_ELEMENTS are dropped and flag the run as overflowed. After the tlast
// item the block stops taking input and, for each of the n stored values,
// reads the buffer through its single read port and compares every entry
// with one comparator, and output stalls can hold it up. Values occurring
// once leave in input order; a run without one gives a single result with
// found clear.
module singleton_element_filter_unit #(
    parameter int MAX_ELEMENTS = sef_pkg::MAX_ELEMENTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // unique_value
    output logic [1:0]  m_axis_tuser,   // {overflowed, found}
    output logic        m_axis_tlast    // run_end
);

    localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);

    logic                               mem_we;
    logic [ADDR_W-1:0]                  mem_waddr;
    logic signed [sef_pkg::VALUE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]                  mem_raddr;
    logic signed [sef_pkg::VALUE_W-1:0] mem_rdata;
    sef_pkg::sef_result_t               push;
    logic                               push_ready;
    logic signed [sef_pkg::VALUE_W-1:0] out_value;
    logic                               out_found;
    logic                               out_overflowed;

    sef_store #(
        .DEPTH  (MAX_ELEMENTS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sef_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .ADDR_W       (ADDR_W),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_value   (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .push       (push),
        .push_ready (push_ready)
    );

    sef_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .push_ready     (push_ready),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_value      (out_value),
        .out_found      (out_found),
        .out_run_end    (m_axis_tlast),
        .out_overflowed (out_overflowed)
    );

    assign m_axis_tdata = out_value;
    assign m_axis_tuser = {out_overflowed, out_found};

endmodule

>>> design/sef_store.sv
// element buffer: one write port, one registered read port
module sef_store #(
    parameter int DEPTH  = sef_pkg::MAX_ELEMENTS,
    parameter int ADDR_W = 6
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [ADDR_W-1:0]                 waddr,
    input  logic signed [sef_pkg::VALUE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]                 raddr,
    output logic signed [sef_pkg::VALUE_W-1:0] rdata
);

    logic signed [sef_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [sef_pkg::VALUE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sef_ctrl.sv
// sequencer: loads the buffer, then counts matches with one shared comparator
module sef_ctrl #(
    parameter int MAX_ELEMENTS = sef_pkg::MAX_ELEMENTS,
    parameter int ADDR_W       = 6,
    parameter int CNT_W        = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [sef_pkg::VALUE_W-1:0] in_value,
    input  logic                               in_last,
    output logic                               mem_we,
    output logic [ADDR_W-1:0]                  mem_waddr,
    output logic signed [sef_pkg::VALUE_W-1:0] mem_wdata,
    output logic [ADDR_W-1:0]                  mem_raddr,
    input  logic signed [sef_pkg::VALUE_W-1:0] mem_rdata,
    output sef_pkg::sef_result_t               push,
    input  logic                               push_ready
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FETCH  = 3'd1;
    localparam logic [2:0] ST_GRAB   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;

    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_MANY = 2'd2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MAX_ELEMENTS);

    logic [2:0]                         state_reg, state_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic                               ovf_reg, ovf_next;
    logic [CNT_W-1:0]                   j_reg, j_next;
    logic [CNT_W-1:0]                   i_reg, i_next;
    logic                               pv_reg, pv_next;
    logic [1:0]                         hits_reg, hits_next;
    logic signed [sef_pkg::VALUE_W-1:0] vj_reg, vj_next;
    logic                               pend_valid_reg, pend_valid_next;
    logic signed [sef_pkg::VALUE_W-1:0] pend_value_reg, pend_value_next;
    logic [CNT_W-1:0]                   j_inc;

    assign in_ready  = (state_reg == ST_IDLE);
    assign mem_waddr = count_reg[ADDR_W-1:0];
    assign mem_wdata = in_value;
    assign j_inc     = j_reg + CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        j_next          = j_reg;
        i_next          = i_reg;
        pv_next         = pv_reg;
        hits_next       = hits_reg;
        vj_next         = vj_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        mem_we          = 1'b0;
        mem_raddr       = '0;
        push            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (count_reg < DEPTH_CNT)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        j_next     = '0;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                mem_raddr  = j_reg[ADDR_W-1:0];
                state_next = ST_GRAB;
            end
            ST_GRAB:
            begin
                vj_next    = mem_rdata;
                mem_raddr  = '0;
                i_next     = CNT_W'(1);
                pv_next    = 1'b1;
                hits_next  = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (pv_reg)
                begin
                    // hit count saturates: two or more means not a singleton
                    if (mem_rdata == vj_reg && hits_reg != HITS_MANY)
                    begin
                        hits_next = hits_reg + 2'd1;
                    end
                    if (i_reg < count_reg)
                    begin
                        mem_raddr = i_reg[ADDR_W-1:0];
                        i_next    = i_reg + CNT_W'(1);
                    end
                    else
                    begin
                        pv_next = 1'b0;
                    end
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // a held singleton leaves only once the next one shows it was not last
                if (hits_reg != HITS_ONE || !pend_valid_reg || push_ready)
                begin
                    if (hits_reg == HITS_ONE)
                    begin
                        if (pend_valid_reg)
                        begin
                            push.valid      = 1'b1;
                            push.value      = pend_value_reg;
                            push.found      = 1'b1;
                            push.run_end    = 1'b0;
                            push.overflowed = ovf_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = vj_reg;
                    end
                    j_next     = j_inc;
                    state_next = (j_inc == count_reg) ? ST_FINISH : ST_FETCH;
                end
            end
            ST_FINISH:
            begin
                if (push_ready)
                begin
                    push.valid      = 1'b1;
                    push.value      = pend_valid_reg ? pend_value_reg : '0;
                    push.found      = pend_valid_reg;
                    push.run_end    = 1'b1;
                    push.overflowed = ovf_reg;
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            pv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            pv_reg         <= pv_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        i_reg          <= i_next;
        hits_reg       <= hits_next;
        vj_reg         <= vj_next;
        pend_value_reg <= pend_value_next;
    end

endmodule

>>> design/sef_out.sv
// output register for result requests
module sef_out (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sef_pkg::sef_result_t               push,
    output logic                               push_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [sef_pkg::VALUE_W-1:0] out_value,
    output logic                               out_found,
    output logic                               out_run_end,
    output logic                               out_overflowed
);

    logic                               valid_reg;
    logic signed [sef_pkg::VALUE_W-1:0] value_reg;
    logic                               found_reg;
    logic                               run_end_reg;
    logic                               ovf_reg;

    assign push_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push.valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            value_reg   <= push.value;
            found_reg   <= push.found;
            run_end_reg <= push.run_end;
            ovf_reg     <= push.overflowed;
        end
    end

    assign out_valid      = valid_reg;
    assign out_value      = value_reg;
    assign out_found      = found_reg;
    assign out_run_end    = run_end_reg;
    assign out_overflowed = ovf_reg;

endmodule

>>> design/sef_checker.sv
// port-level checks for the singleton element filter, bound to the top level
module sef_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // the empty answer always closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("not-found result without run end");

    // the empty answer carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("not-found result with nonzero value");

    // input stops right after the last request of a run
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during evaluation");

endmodule

bind singleton_element_filter_unit sef_checker u_sef_checker (.*);

>>> verif/singleton_element_filter_unit_tb.sv
// testbench for the singleton element filter: directed and random runs checked against a predictor
module singleton_element_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASE_ITEMS  = 20;

    typedef struct packed {
        logic [31:0] value;
        logic        found;
        logic        run_end;
        logic        overflowed;
    } unique_result_t;

    class unique_scoreboard;
        logic [31:0]    run_values[$];
        bit             run_overflow;
        unique_result_t expected_q[$];
        int             mismatches;

        // stores one accepted request; a final one resolves the run
        function void note_request(logic [31:0] v, logic fin);
            unique_result_t r;
            logic [31:0]    singles[$];
            int             hits;
            if (run_values.size() < sef_pkg::MAX_ELEMENTS)
                run_values.push_back(v);
            else
                run_overflow = 1'b1;
            if (!fin)
                return;
            foreach (run_values[j]) begin
                hits = 0;
                foreach (run_values[i])
                    if (run_values[i] === run_values[j])
                        hits++;
                if (hits == 1)
                    singles.push_back(run_values[j]);
            end
            if (singles.size() == 0) begin
                r.value      = '0;
                r.found      = 1'b0;
                r.run_end    = 1'b1;
                r.overflowed = run_overflow;
                expected_q.push_back(r);
            end
            else begin
                foreach (singles[k]) begin
                    r.value      = singles[k];
                    r.found      = 1'b1;
                    r.run_end    = (k == singles.size() - 1);
                    r.overflowed = run_overflow;
                    expected_q.push_back(r);
                end
            end
            run_values.delete();
            run_overflow = 1'b0;
        endfunction

        function void check_result(logic [31:0] data, logic [1:0] user, logic last);
            unique_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h found %b overflowed %b run_end %b",
                             data, user[0], user[1], last);
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.value || user[0] !== want.found ||
                user[1] !== want.overflowed || last !== want.run_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %h found %b overflowed %b run_end %b, %s",
                             want.value, want.found, want.overflowed, want.run_end,
                             $sformatf("got value %h found %b overflowed %b run_end %b",
                                       data, user[0], user[1], last));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    unique_scoreboard filter_sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int items_sent;
    int cycle_count;

    singleton_element_filter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side: random stalls, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end
        else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            filter_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // tvalid stays high into the next call so back-to-back requests never toggle it
    task automatic send_item(input logic [31:0] v, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        filter_sb.note_request(v, fin);
        items_sent++;
    endtask

    // mostly values from a small pool so that duplicates are common
    task automatic send_run(input int len);
        logic [31:0] pool[8];
        int          pool_n;
        logic [31:0] v;
        pool_n = $urandom_range(1, 8);
        for (int p = 0; p < 8; p++)
            pool[p] = $urandom;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) < 3)
                v = $urandom;
            else
                v = pool[$urandom_range(pool_n - 1)];
            send_item(v, k == len - 1);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (filter_sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        filter_sb       = new();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        items_sent      = 0;
        cycle_count     = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single value, then a pair with nothing unique
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b1);
        // extremes, and values that differ only in the sign bit
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h7FFF_FFFF, 1'b0);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'hFFFF_FFFF, 1'b0);
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h8000_0001, 1'b1);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b0);
        send_item(32'd7, 1'b1);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);
        send_item(32'h1234_5678, 1'b1);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            // receiver holds off while runs keep coming, so the input backs up
            if (phase == 2)
                hold_off_cycles = 2500;
            // buffer overflow, where the final request itself gets dropped
            if (phase == 0)
                send_run($urandom_range(sef_pkg::MAX_ELEMENTS + 1, sef_pkg::MAX_ELEMENTS + 6));
            // exactly full buffer, no overflow
            if (phase == 1)
                send_run(sef_pkg::MAX_ELEMENTS);
            if (phase == 3)
                send_run($urandom_range(sef_pkg::MAX_ELEMENTS + 2, sef_pkg::MAX_ELEMENTS + 8));
            for (int target = items_sent + PHASE_ITEMS; items_sent < target; )
                send_run($urandom_range(1, $urandom_range(3, 20)));
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (filter_sb.mismatches == 0 && filter_sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
design/sef_pkg.sv
design/sef_store.sv
design/sef_ctrl.sv
design/sef_out.sv
design/singleton_element_filter_unit.sv
design/sef_checker.sv
verif/singleton_element_filter_unit_tb.sv
